@@ sv/cbse_pkg.sv @@
// ----------------------------------------------------------------------------
// cbse_pkg
// shared types, widths and helpers of the blocked sparse encoder
// ----------------------------------------------------------------------------
package cbse_pkg;

  localparam int unsigned FIELD_W = 32;   // coordinate and value field width
  localparam int unsigned BC_W    = 31;   // block coordinate field width
  localparam int unsigned OFS_W   = 7;    // element offset field width
  localparam int unsigned NUM_COORDS = 4; // coordinate fields per beat
  localparam int unsigned CFG_W   = 3;    // widest configuration register
  localparam int unsigned CFG_IDX_W = 1;  // configuration register index width
  localparam int unsigned Q_DEPTH = 2;    // entries between front and back

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] BLOCK_BITS_RST = 3'd7;
  localparam logic [CFG_W-1:0] MODE_COUNT_RST = 3'd3;

  localparam logic [FIELD_W-1:0] SAT_MAX = '1;

  typedef struct packed {
    logic [FIELD_W-1:0] coord_0;
    logic [FIELD_W-1:0] coord_1;
    logic [FIELD_W-1:0] coord_2;
    logic [FIELD_W-1:0] coord_3;
    logic [FIELD_W-1:0] nonzero_value;
    logic               last_item;
  } in_beat_t;

  typedef struct packed {
    logic [OFS_W-1:0]   elem_offset_0;
    logic [OFS_W-1:0]   elem_offset_1;
    logic [OFS_W-1:0]   elem_offset_2;
    logic [OFS_W-1:0]   elem_offset_3;
    logic [FIELD_W-1:0] value_out;
    logic               new_block;
    logic [BC_W-1:0]    block_coord_0;
    logic [BC_W-1:0]    block_coord_1;
    logic [BC_W-1:0]    block_coord_2;
    logic [BC_W-1:0]    block_coord_3;
    logic [FIELD_W-1:0] item_position;
    logic [FIELD_W-1:0] max_block_nnz;
  } out_beat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [FIELD_W-1:0] sat_inc(input logic [FIELD_W-1:0] v);
    sat_inc = (v == SAT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

@@ sv/coo_to_blocked_sparse_encoder.sv @@
// ----------------------------------------------------------------------------
// coo_to_blocked_sparse_encoder
// blocks a block-sorted coo nonzero stream into block coordinates and offsets
// ----------------------------------------------------------------------------
// datapath: an accepted beat is written into the queue and from there into the
//   result register that drives out_valid; an output stall can hold it between
// throughput: one beat per cycle while the output does not stall; the block
//   compare in the back end is combinational; an output stall reaches in_stall
//   only once the two-entry queue fills
// reset: synchronous active-low; registers return to block_bits 7 and
//   mode_count 3, the stream state clears and the queue empties
// ----------------------------------------------------------------------------
module coo_to_blocked_sparse_encoder #(
  parameter int unsigned MAX_MODES   = 4,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // nonzero input beats
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cbse_pkg::in_beat_t                in_beat,
  // blocked result beats
  output logic                              out_valid,
  input  logic                              out_stall,
  output cbse_pkg::out_beat_t               out_beat,
  // register writes
  input  logic                              cfg_we,
  input  logic [cbse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbse_pkg::CFG_W-1:0]        cfg_data
);

  // only as many lanes as there are coordinate fields are ever in use
  localparam int unsigned LANES = (MAX_MODES < cbse_pkg::NUM_COORDS) ?
                                  MAX_MODES : cbse_pkg::NUM_COORDS;
  // the smallest block shift is one bit, so a block coordinate has one bit
  // fewer than the coordinate
  localparam int unsigned BW = COORD_WIDTH - 1;
  // queue entry: last flag, value, lane-active mask, offsets, block coords
  localparam int unsigned EW = 1 + cbse_pkg::FIELD_W + LANES
                               + LANES * cbse_pkg::OFS_W + LANES * BW;

  logic [cbse_pkg::CFG_W-1:0] block_bits_r, block_bits_nxt;
  logic [cbse_pkg::CFG_W-1:0] mode_count_r, mode_count_nxt;

  cbse_pkg::q_status_t q_status;
  logic                q_push;
  logic                q_pop;
  logic [EW-1:0]       q_wdata;
  logic [EW-1:0]       q_rdata;

  // register file: the user must write it only while the block is idle; the block itself does not enforce this
  always_comb begin
    block_bits_nxt = block_bits_r;
    mode_count_nxt = mode_count_r;
    if (cfg_we) begin
      case (cfg_index)
        cbse_pkg::CFG_BLOCK_BITS: block_bits_nxt = cfg_data;
        cbse_pkg::CFG_MODE_COUNT: mode_count_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bits_r <= cbse_pkg::BLOCK_BITS_RST;
      mode_count_r <= cbse_pkg::MODE_COUNT_RST;
    end else begin
      block_bits_r <= block_bits_nxt;
      mode_count_r <= mode_count_nxt;
    end
  end

  // front: coordinate split into block coordinate and element offset
  cbse_front #(
    .LANES   (LANES),
    .COORD_W (COORD_WIDTH),
    .EW      (EW)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .block_bits (block_bits_r),
    .mode_count (mode_count_r),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // decoupling queue between front and back
  cbse_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .status    (q_status)
  );

  // back: block compare, counters and the result register
  cbse_back #(
    .LANES   (LANES),
    .COORD_W (COORD_WIDTH),
    .EW      (EW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

@@ sv/cbse_queue.sv @@
// ----------------------------------------------------------------------------
// cbse_queue
// short fifo between the classifying front and the block tracking back
// ----------------------------------------------------------------------------
module cbse_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output cbse_pkg::q_status_t status
);

  localparam int unsigned PTR_W = (cbse_pkg::Q_DEPTH > 1) ? $clog2(cbse_pkg::Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(cbse_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(cbse_pkg::Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(cbse_pkg::Q_DEPTH);

  logic [WIDTH-1:0] mem [cbse_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = mem[rd_ptr_r];
  assign status.full  = (cnt_r == FULL_CNT);
  assign status.empty = (cnt_r == '0);

endmodule

@@ sv/cbse_front.sv @@
// ----------------------------------------------------------------------------
// cbse_front
// accepts nonzero beats and splits coordinates into block and offset parts
// ----------------------------------------------------------------------------
module cbse_front #(
  parameter int unsigned LANES   = 4,
  parameter int unsigned COORD_W = 32,
  parameter int unsigned EW      = 8
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cbse_pkg::in_beat_t            in_beat,
  input  logic [cbse_pkg::CFG_W-1:0]    block_bits,
  input  logic [cbse_pkg::CFG_W-1:0]    mode_count,
  input  cbse_pkg::q_status_t           q_status,
  output logic                          q_push,
  output logic [EW-1:0]                 q_data
);

  localparam int unsigned BW = COORD_W - 1;

  logic [cbse_pkg::FIELD_W-1:0]      coord [cbse_pkg::NUM_COORDS];
  logic [cbse_pkg::CFG_W-1:0]        shift;
  logic [cbse_pkg::OFS_W-1:0]        ofs_mask;
  logic [LANES-1:0]                  active;
  logic [LANES-1:0][BW-1:0]          bc;
  logic [LANES-1:0][cbse_pkg::OFS_W-1:0] eo;

  assign coord[0] = in_beat.coord_0;
  assign coord[1] = in_beat.coord_1;
  assign coord[2] = in_beat.coord_2;
  assign coord[3] = in_beat.coord_3;

  // a zero block size behaves as one bit
  assign shift    = (block_bits == '0) ? cbse_pkg::CFG_W'(1) : block_bits;
  assign ofs_mask = cbse_pkg::OFS_W'((8'd1 << shift) - 8'd1);

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [COORD_W-1:0] c;
    assign c         = coord[g][COORD_W-1:0];
    // lane 0 always in use, others while mode_count reaches past them
    assign active[g] = (g == 0) || (mode_count > cbse_pkg::CFG_W'(g));
    assign bc[g]     = active[g] ? BW'(c >> shift) : '0;
    assign eo[g]     = active[g] ? (c[cbse_pkg::OFS_W-1:0] & ofs_mask) : '0;
  end

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;
  assign q_data   = {in_beat.last_item, in_beat.nonzero_value, active, eo, bc};

endmodule

@@ sv/cbse_back.sv @@
// ----------------------------------------------------------------------------
// cbse_back
// block compare, position and count tracking, result register
// ----------------------------------------------------------------------------
module cbse_back #(
  parameter int unsigned LANES   = 4,
  parameter int unsigned COORD_W = 32,
  parameter int unsigned EW      = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cbse_pkg::q_status_t    q_status,
  input  logic [EW-1:0]          q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output cbse_pkg::out_beat_t    out_beat
);

  localparam int unsigned BW = COORD_W - 1;

  logic                                  last;
  logic [cbse_pkg::FIELD_W-1:0]          value;
  logic [LANES-1:0]                      active;
  logic [LANES-1:0][cbse_pkg::OFS_W-1:0] eo;
  logic [LANES-1:0][BW-1:0]              bc;

  logic [LANES-1:0][BW-1:0]     prior_r, prior_nxt;
  logic                         first_r, first_nxt;
  logic [cbse_pkg::FIELD_W-1:0] pos_r, pos_nxt;
  logic [cbse_pkg::FIELD_W-1:0] cnt_r, cnt_nxt;
  logic [cbse_pkg::FIELD_W-1:0] max_r, max_nxt;
  logic                         out_valid_r, out_valid_nxt;
  cbse_pkg::out_beat_t          out_beat_r, out_beat_nxt;

  logic [LANES-1:0]             lane_diff;
  logic                         opens;
  logic [cbse_pkg::FIELD_W-1:0] cnt_upd, max_upd;
  logic [cbse_pkg::BC_W-1:0]    bc_ext [cbse_pkg::NUM_COORDS];
  logic [cbse_pkg::OFS_W-1:0]   eo_ext [cbse_pkg::NUM_COORDS];

  assign {last, value, active, eo, bc} = q_data;

  for (genvar g = 0; g < LANES; g++) begin : g_cmp
    assign lane_diff[g] = active[g] && (bc[g] != prior_r[g]);
  end

  for (genvar g = 0; g < cbse_pkg::NUM_COORDS; g++) begin : g_ext
    if (g < LANES) begin : g_used
      assign bc_ext[g] = cbse_pkg::BC_W'(bc[g]);
      assign eo_ext[g] = eo[g];
    end else begin : g_unused
      assign bc_ext[g] = '0;
      assign eo_ext[g] = '0;
    end
  end

  assign q_pop   = !q_status.empty && (!out_valid_r || !out_stall);
  assign opens   = first_r || (|lane_diff);
  assign cnt_upd = opens ? cbse_pkg::FIELD_W'(1) : cbse_pkg::sat_inc(cnt_r);
  assign max_upd = (cnt_upd > max_r) ? cnt_upd : max_r;

  always_comb begin
    prior_nxt     = prior_r;
    first_nxt     = first_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    out_beat_nxt  = out_beat_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      out_valid_nxt              = 1'b1;
      out_beat_nxt.elem_offset_0 = eo_ext[0];
      out_beat_nxt.elem_offset_1 = eo_ext[1];
      out_beat_nxt.elem_offset_2 = eo_ext[2];
      out_beat_nxt.elem_offset_3 = eo_ext[3];
      out_beat_nxt.value_out     = value;
      out_beat_nxt.new_block     = opens;
      out_beat_nxt.block_coord_0 = bc_ext[0];
      out_beat_nxt.block_coord_1 = bc_ext[1];
      out_beat_nxt.block_coord_2 = bc_ext[2];
      out_beat_nxt.block_coord_3 = bc_ext[3];
      out_beat_nxt.item_position = pos_r;
      out_beat_nxt.max_block_nnz = max_upd;
      if (last) begin
        // end of tensor: stream state back to its reset values
        prior_nxt = '0;
        first_nxt = 1'b1;
        pos_nxt   = '0;
        cnt_nxt   = '0;
        max_nxt   = '0;
      end else begin
        if (opens) begin
          prior_nxt = bc;
        end
        first_nxt = 1'b0;
        pos_nxt   = cbse_pkg::sat_inc(pos_r);
        cnt_nxt   = cnt_upd;
        max_nxt   = max_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r     <= '0;
      first_r     <= 1'b1;
      pos_r       <= '0;
      cnt_r       <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prior_r     <= prior_nxt;
      first_r     <= first_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // running maximum never trails the current block count
  a_max_covers_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    max_r >= cnt_r) else $error("block max below current count");

  // inside a stream the current block holds at least one nonzero
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !first_r |-> (cnt_r != '0)) else $error("open block with zero count");

  // the first beat of a stream always opens a block
  a_first_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && first_r) |=> (out_valid_r && out_beat_r.new_block))
    else $error("first beat did not open a block");

  // a last beat returns the stream state to its start
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && last) |=> (first_r && (pos_r == '0) && (max_r == '0)))
    else $error("stream state not cleared after last beat");

endmodule

@@ test/tb_coo_to_blocked_sparse_encoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_coo_to_blocked_sparse_encoder
// block-sorted nonzero streams over several block sizes and mode counts,
// scoreboard predicts each blocked beat, random idles and stalls both sides
// ----------------------------------------------------------------------------
module tb_coo_to_blocked_sparse_encoder;

  localparam int RANDOM_PHASES    = 10;
  localparam int ITEMS_PER_PHASE  = 113;
  localparam int LONG_HOLD_AT     = 300;     // accepted beats before the long hold
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES     = 20;
  localparam int CYCLE_LIMIT      = 400000;

  // --------------------------------------------------------------------------
  // blocking predictor and result store
  // --------------------------------------------------------------------------
  class block_tracker;
    logic [cbse_pkg::CFG_W-1:0]   block_bits;
    logic [cbse_pkg::CFG_W-1:0]   mode_count;
    logic [cbse_pkg::BC_W-1:0]    prior_block [cbse_pkg::NUM_COORDS];
    bit                           first_pending;
    logic [cbse_pkg::FIELD_W-1:0] position_count;
    logic [cbse_pkg::FIELD_W-1:0] nnz_in_block;
    logic [cbse_pkg::FIELD_W-1:0] nnz_peak;
    cbse_pkg::out_beat_t          pending_blocked [$];
    int                           fails;
    int                           checked;

    function new();
      block_bits = cbse_pkg::BLOCK_BITS_RST;
      mode_count = cbse_pkg::MODE_COUNT_RST;
      fails      = 0;
      checked    = 0;
      restart_tensor();
    endfunction

    function void restart_tensor();
      foreach (prior_block[m]) prior_block[m] = '0;
      first_pending  = 1'b1;
      position_count = '0;
      nnz_in_block   = '0;
      nnz_peak       = '0;
    endfunction

    function logic [cbse_pkg::FIELD_W-1:0] saturating_step(
        logic [cbse_pkg::FIELD_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void set_reg(logic [cbse_pkg::CFG_IDX_W-1:0] idx,
                          logic [cbse_pkg::CFG_W-1:0] v);
      if (idx == cbse_pkg::CFG_BLOCK_BITS) begin
        block_bits = v;
      end else begin
        mode_count = v;
      end
    endfunction

    // work out the blocked beat that one accepted nonzero must produce
    function void note_nonzero(cbse_pkg::in_beat_t b);
      logic [cbse_pkg::FIELD_W-1:0] coord [cbse_pkg::NUM_COORDS];
      logic [cbse_pkg::BC_W-1:0]    blk [cbse_pkg::NUM_COORDS];
      logic [cbse_pkg::OFS_W-1:0]   ofs [cbse_pkg::NUM_COORDS];
      int                           bits;
      int                           modes;
      bit                           opens;
      cbse_pkg::out_beat_t          e;
      bits  = (block_bits == 0) ? 1 : int'(block_bits);
      modes = (mode_count == 0) ? 1 :
              (mode_count > cbse_pkg::NUM_COORDS) ? cbse_pkg::NUM_COORDS :
              int'(mode_count);
      coord[0] = b.coord_0;
      coord[1] = b.coord_1;
      coord[2] = b.coord_2;
      coord[3] = b.coord_3;
      opens = first_pending;
      for (int m = 0; m < cbse_pkg::NUM_COORDS; m++) begin
        if (m < modes) begin
          blk[m] = cbse_pkg::BC_W'(coord[m] >> bits);
          ofs[m] = cbse_pkg::OFS_W'(coord[m] & ((32'd1 << bits) - 32'd1));
          if (blk[m] != prior_block[m]) opens = 1'b1;
        end else begin
          blk[m] = '0;
          ofs[m] = '0;
        end
      end
      if (opens) begin
        prior_block   = blk;
        nnz_in_block  = 32'd1;
        first_pending = 1'b0;
      end else begin
        nnz_in_block = saturating_step(nnz_in_block);
      end
      if (nnz_in_block > nnz_peak) nnz_peak = nnz_in_block;
      e.elem_offset_0 = ofs[0];
      e.elem_offset_1 = ofs[1];
      e.elem_offset_2 = ofs[2];
      e.elem_offset_3 = ofs[3];
      e.value_out     = b.nonzero_value;
      e.new_block     = opens;
      e.block_coord_0 = blk[0];
      e.block_coord_1 = blk[1];
      e.block_coord_2 = blk[2];
      e.block_coord_3 = blk[3];
      e.item_position = position_count;
      e.max_block_nnz = nnz_peak;
      pending_blocked.push_back(e);
      position_count = saturating_step(position_count);
      if (b.last_item) restart_tensor();
    endfunction

    function void flag(string what, logic [cbse_pkg::FIELD_W-1:0] want_v,
                       logic [cbse_pkg::FIELD_W-1:0] got_v);
      fails++;
      if (fails <= 10) begin
        $display("mismatch at result %0d, %0s: expected %h, got %h",
                 checked, what, want_v, got_v);
      end
    endfunction

    function void compare_field(string what, logic [cbse_pkg::FIELD_W-1:0] want_v,
                                logic [cbse_pkg::FIELD_W-1:0] got_v);
      if (got_v !== want_v) flag(what, want_v, got_v);
    endfunction

    function void check_blocked_beat(cbse_pkg::out_beat_t got);
      cbse_pkg::out_beat_t want;
      if (pending_blocked.size() == 0) begin
        flag("result with none pending, item_position", '0, got.item_position);
        return;
      end
      want = pending_blocked.pop_front();
      compare_field("elem_offset_0", want.elem_offset_0, got.elem_offset_0);
      compare_field("elem_offset_1", want.elem_offset_1, got.elem_offset_1);
      compare_field("elem_offset_2", want.elem_offset_2, got.elem_offset_2);
      compare_field("elem_offset_3", want.elem_offset_3, got.elem_offset_3);
      compare_field("value_out", want.value_out, got.value_out);
      compare_field("new_block", want.new_block, got.new_block);
      compare_field("block_coord_0", want.block_coord_0, got.block_coord_0);
      compare_field("block_coord_1", want.block_coord_1, got.block_coord_1);
      compare_field("block_coord_2", want.block_coord_2, got.block_coord_2);
      compare_field("block_coord_3", want.block_coord_3, got.block_coord_3);
      compare_field("item_position", want.item_position, got.item_position);
      compare_field("max_block_nnz", want.max_block_nnz, got.max_block_nnz);
      checked++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block hookup
  // --------------------------------------------------------------------------
  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  cbse_pkg::in_beat_t             in_beat   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  cbse_pkg::out_beat_t            out_beat;
  logic                           cfg_we    = 1'b0;
  logic [cbse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cbse_pkg::CFG_W-1:0]     cfg_data  = '0;

  block_tracker tracker = new();

  int in_accepted = 0;
  int cycle_count = 0;
  int gen_bits    = 7;  // block size the generator aims at, after clamping
  int gen_modes   = 3;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  coo_to_blocked_sparse_encoder #(
    .MAX_MODES   (4),
    .COORD_WIDTH (32)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // result side: check every accepted beat, pace the stall
  // --------------------------------------------------------------------------
  // values read right after the edge are the ones the block saw at that edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_blocked_beat(out_beat);
  end

  // mostly short stalls, some open stretches, a few long holds; once in the
  // run a long hold lets the two-entry queue fill so the input stalls too
  initial begin : rx_pacing
    int stall_left;
    int free_left;
    int r;
    bit long_done;
    stall_left = 0;
    free_left  = 0;
    long_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_done && in_accepted >= LONG_HOLD_AT) begin
        long_done  = 1'b1;
        stall_left = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && free_left == 0) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          free_left = $urandom_range(1, 40);
        end else if (r < 9) begin
          stall_left = $urandom_range(1, 3);
        end else begin
          stall_left = $urandom_range(8, 30);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        if (free_left > 0) free_left--;
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  function automatic int pick_gap(input bit gapless);
    int r;
    if (gapless) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic cbse_pkg::in_beat_t nz(input logic [31:0] c0,
                                            input logic [31:0] c1,
                                            input logic [31:0] c2,
                                            input logic [31:0] c3,
                                            input logic [31:0] val,
                                            input logic last);
    cbse_pkg::in_beat_t b;
    b.coord_0       = c0;
    b.coord_1       = c1;
    b.coord_2       = c2;
    b.coord_3       = c3;
    b.nonzero_value = val;
    b.last_item     = last;
    return b;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // offer one beat, hold it until taken, then idle for the given gap; valid
  // stays high between back-to-back beats
  task automatic send_nonzero(input cbse_pkg::in_beat_t b, input int gap);
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    in_accepted++;
    tracker.note_nonzero(b);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending_blocked.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers change only with the block idle
  task automatic apply_config(input int bb, input int mc);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= cbse_pkg::CFG_BLOCK_BITS;
    cfg_data  <= cbse_pkg::CFG_W'(bb);
    @(posedge clk);
    tracker.set_reg(cbse_pkg::CFG_BLOCK_BITS, cbse_pkg::CFG_W'(bb));
    cfg_index <= cbse_pkg::CFG_MODE_COUNT;
    cfg_data  <= cbse_pkg::CFG_W'(mc);
    @(posedge clk);
    tracker.set_reg(cbse_pkg::CFG_MODE_COUNT, cbse_pkg::CFG_W'(mc));
    cfg_we    <= 1'b0;
    gen_bits  = (bb == 0) ? 1 : bb;
    gen_modes = (mc == 0) ? 1 : (mc > 4) ? 4 : mc;
  endtask

  task automatic run_directed();
    // reset registers: 128-wide blocks, three modes
    send_nonzero(nz(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0), pick_gap(0));
    // same block, unused mode 3 all ones is ignored
    send_nonzero(nz(32'h7f, 32'h7f, 32'h7f, '1, '1, 1'b0), pick_gap(0));
    send_nonzero(nz(32'h05, 32'h40, 32'h01, 32'h12345678, 32'h80000000, 1'b0),
                 pick_gap(0));
    // top corner of the coordinate space
    send_nonzero(nz('1, '1, '1, '1, 32'ha5a5a5a5, 1'b0), pick_gap(0));
    send_nonzero(nz(32'hffffff80, '1, 32'hffffffc0, 32'h0, 32'h1, 1'b0), pick_gap(0));
    // neighbor blocks, one mode at a time
    send_nonzero(nz(32'h80, 32'h0, 32'h0, 32'h0, 32'h5a5a5a5a, 1'b0), pick_gap(0));
    send_nonzero(nz(32'h80, 32'h80, 32'h0, 32'h0, 32'h7, 1'b0), pick_gap(0));
    send_nonzero(nz(32'h80, 32'h80, 32'hff, 32'h0, 32'h8, 1'b1), pick_gap(0));
    // new tensor opens a block even where it matches the cleared prior block
    send_nonzero(nz(32'h0, 32'h0, 32'h0, 32'h0, 32'h9, 1'b0), pick_gap(0));
    send_nonzero(nz(32'h10, 32'h0, 32'h0, 32'h0, 32'ha, 1'b1), pick_gap(0));

    // zero registers clamp to one-bit blocks and a single mode
    apply_config(0, 0);
    send_nonzero(nz(32'h3, '1, '1, '1, 32'h11, 1'b0), pick_gap(0));
    send_nonzero(nz(32'h2, 32'h0, 32'h0, 32'h0, 32'h12, 1'b0), pick_gap(0));
    send_nonzero(nz(32'h4, 32'h5, 32'h6, 32'h7, 32'h13, 1'b0), pick_gap(0));
    send_nonzero(nz('1, 32'h0, 32'h0, 32'h0, 32'h14, 1'b1), pick_gap(0));

    // smallest blocks, all four modes, mode 3 alone moves the block
    apply_config(1, 4);
    send_nonzero(nz(32'h0, 32'h0, 32'h0, 32'h0, 32'h15, 1'b0), pick_gap(0));
    send_nonzero(nz(32'h1, 32'h1, 32'h1, 32'h1, 32'h16, 1'b0), pick_gap(0));
    send_nonzero(nz(32'h1, 32'h1, 32'h1, 32'h2, 32'h17, 1'b0), pick_gap(0));
    send_nonzero(nz(32'h1, 32'h1, 32'h1, 32'h3, 32'h18, 1'b1), pick_gap(0));

    // mode count above the maximum clamps to four
    apply_config(7, 6);
    send_nonzero(nz(32'h0, 32'h0, 32'h0, 32'h7f, 32'h19, 1'b0), pick_gap(0));
    send_nonzero(nz(32'h0, 32'h0, 32'h0, 32'h80, 32'h1a, 1'b0), pick_gap(0));
    send_nonzero(nz(32'h7f, 32'h7f, 32'h7f, 32'hff, 32'h1b, 1'b1), pick_gap(0));
  endtask

  // runs of nonzeros inside one block, moving to a neighbor block or jumping
  // anywhere between runs, tensors ending now and then; a tenth is noise
  task automatic run_random_phase(input int n_items, input bit gapless);
    logic [31:0]        base [4];
    logic [31:0]        c [4];
    logic [31:0]        ofs_mask;
    cbse_pkg::in_beat_t b;
    int                 sent;
    int                 run_len;
    int                 r;
    int                 m;
    ofs_mask = (32'd1 << gen_bits) - 32'd1;
    sent     = 0;
    for (int k = 0; k < 4; k++) base[k] = $urandom;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        b = nz($urandom, $urandom, $urandom, $urandom, pick_value(),
               ($urandom_range(0, 15) == 0));
        send_nonzero(b, pick_gap(gapless));
        sent++;
      end else begin
        if (r < 6) begin
          m = $urandom_range(0, gen_modes - 1);
          if ($urandom_range(0, 1)) begin
            base[m] = base[m] + ofs_mask + 32'd1;
          end else begin
            base[m] = base[m] - ofs_mask - 32'd1;
          end
        end else begin
          for (int k = 0; k < 4; k++) base[k] = $urandom;
        end
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
        for (int j = 0; j < run_len && sent < n_items; j++) begin
          // unused modes carry garbage that must not matter
          for (int k = 0; k < 4; k++) begin
            c[k] = (k < gen_modes) ? ((base[k] & ~ofs_mask) | ($urandom & ofs_mask))
                                   : $urandom;
          end
          b = nz(c[0], c[1], c[2], c[3], pick_value(),
                 (j == run_len - 1) && ($urandom_range(0, 5) == 0));
          send_nonzero(b, pick_gap(gapless));
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin : main_flow
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // fixed settings first, then two random settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_config(1, 4);
        1: apply_config(7, 1);
        2: apply_config(3, 2);
        3: apply_config(0, 5);
        4: apply_config(5, 4);
        5: apply_config(2, 3);
        6: apply_config(7, 7);
        7: apply_config(4, 0);
        default: apply_config($urandom_range(0, 7), $urandom_range(0, 7));
      endcase
      run_random_phase(ITEMS_PER_PHASE, ($urandom_range(0, 3) == 0));
    end

    // let the last results out, then watch for strays
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.fails == 0 && tracker.pending_blocked.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/cbse_pkg.sv
sv/cbse_queue.sv
sv/cbse_front.sv
sv/cbse_back.sv
sv/coo_to_blocked_sparse_encoder.sv
test/tb_coo_to_blocked_sparse_encoder.sv
